@@ design/cbac_pkg.sv @@
// Shared types and constants for the checkerboard alpha compositor.
// No dependencies; used by the register block, pipeline and top level.
package cbac_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hff;
  localparam logic [ChanW-1:0] AlphaClear  = 8'h00;
  localparam logic [15:0]      RoundHalf   = 16'h0080;
  localparam logic [15:0]      AlphaBias   = 16'h00ff;

  typedef enum logic [2:0] {
    RegColorOne    = 3'd0,
    RegColorTwo    = 3'd1,
    RegOpacity     = 3'd2,
    RegXOffset     = 3'd3,
    RegYOffset     = 3'd4,
    RegShift       = 3'd5,
    RegSrcAlpha    = 3'd6,
    RegFourChannel = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0]  color_one;
    logic [ColorW-1:0]  color_two;
    logic [ChanW-1:0]   overall_opacity;
    logic [OffsetW-1:0] checker_x_offset;
    logic [OffsetW-1:0] checker_y_offset;
    logic [ShiftW-1:0]  checker_shift;
    logic               source_alpha_present;
    logic               four_channel_output;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    color_one:            24'h000000,
    color_two:            24'hffffff,
    overall_opacity:      8'hff,
    checker_x_offset:     12'h000,
    checker_y_offset:     12'h000,
    checker_shift:        4'd3,
    source_alpha_present: 1'b1,
    four_channel_output:  1'b0
  };

endpackage

@@ design/cbac_intf.sv @@
// Pixel channel interfaces: source pixel in, composited pixel out.
// Depends on cbac_pkg for the channel width.
interface cbac_in_if #(
  parameter int unsigned CoordBits = 12
);
  logic                       valid;
  logic                       ready;
  logic [cbac_pkg::ChanW-1:0] src_red;
  logic [cbac_pkg::ChanW-1:0] src_green;
  logic [cbac_pkg::ChanW-1:0] src_blue;
  logic [cbac_pkg::ChanW-1:0] src_alpha;
  logic [CoordBits-1:0]       out_column;
  logic [CoordBits-1:0]       out_row;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha, out_column, out_row,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha, out_column, out_row,
    output ready
  );
endinterface

interface cbac_out_if;
  logic                       valid;
  logic                       ready;
  logic [cbac_pkg::ChanW-1:0] dst_red;
  logic [cbac_pkg::ChanW-1:0] dst_green;
  logic [cbac_pkg::ChanW-1:0] dst_blue;
  logic [cbac_pkg::ChanW-1:0] dst_alpha;
  logic                       alpha_write;

  modport source (
    output valid, dst_red, dst_green, dst_blue, dst_alpha, alpha_write,
    input  ready
  );
  modport sink (
    input  valid, dst_red, dst_green, dst_blue, dst_alpha, alpha_write,
    output ready
  );
endinterface

@@ design/cbac_regs.sv @@
// APB configuration registers for the compositor.
// Depends on cbac_pkg (cfg_t, register indexes, reset values).
module cbac_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbac_pkg::ApbAddrW-1:0] paddr,
  input  logic [cbac_pkg::ApbDataW-1:0] pwdata,
  output logic [cbac_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output cbac_pkg::cfg_t                cfg_o
);

  cbac_pkg::cfg_t      cfg_q;
  cbac_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign idx    = cbac_pkg::reg_idx_e'(paddr[cbac_pkg::ApbAddrW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cbac_pkg::CfgReset;
    end else if (wr_en) begin
      unique case (idx)
        cbac_pkg::RegColorOne:    cfg_q.color_one <= pwdata[cbac_pkg::ColorW-1:0];
        cbac_pkg::RegColorTwo:    cfg_q.color_two <= pwdata[cbac_pkg::ColorW-1:0];
        cbac_pkg::RegOpacity:     cfg_q.overall_opacity <= pwdata[cbac_pkg::ChanW-1:0];
        cbac_pkg::RegXOffset:     cfg_q.checker_x_offset <= pwdata[cbac_pkg::OffsetW-1:0];
        cbac_pkg::RegYOffset:     cfg_q.checker_y_offset <= pwdata[cbac_pkg::OffsetW-1:0];
        cbac_pkg::RegShift:       cfg_q.checker_shift <= pwdata[cbac_pkg::ShiftW-1:0];
        cbac_pkg::RegSrcAlpha:    cfg_q.source_alpha_present <= pwdata[0];
        cbac_pkg::RegFourChannel: cfg_q.four_channel_output <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      cbac_pkg::RegColorOne:    prdata = {8'h00, cfg_q.color_one};
      cbac_pkg::RegColorTwo:    prdata = {8'h00, cfg_q.color_two};
      cbac_pkg::RegOpacity:     prdata = {24'h000000, cfg_q.overall_opacity};
      cbac_pkg::RegXOffset:     prdata = {20'h00000, cfg_q.checker_x_offset};
      cbac_pkg::RegYOffset:     prdata = {20'h00000, cfg_q.checker_y_offset};
      cbac_pkg::RegShift:       prdata = {28'h0000000, cfg_q.checker_shift};
      cbac_pkg::RegSrcAlpha:    prdata = {31'h00000000, cfg_q.source_alpha_present};
      cbac_pkg::RegFourChannel: prdata = {31'h00000000, cfg_q.four_channel_output};
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ design/cbac_pipe.sv @@
// Three-stage compositing pipeline: alpha and checker parity, per-channel
// blend products, rounding and output register. Depends on cbac_pkg and
// the cbac_in_if / cbac_out_if interfaces.
module cbac_pipe #(
  parameter int unsigned CoordBits = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cbac_pkg::cfg_t cfg_i,
  cbac_in_if.sink        pix_i,
  cbac_out_if.source     pix_o
);

  localparam int unsigned ChanW = cbac_pkg::ChanW;
  localparam int unsigned OffW  = cbac_pkg::OffsetW;

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // each stage moves on when empty or when the next one moves
  assign adv3        = !v3_q || pix_o.ready;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign pix_i.ready = adv1;

  // ---- stage 1: effective alpha, checker parity
  logic [CoordBits-1:0] xoff, yoff;
  logic [CoordBits:0]   xsum, ysum, xsh, ysh;
  logic [15:0]          amul;
  logic [15:0]          abias;
  logic [ChanW-1:0]     alpha_d;
  logic                 pick_d;

  for (genvar i = 0; i < CoordBits; i++) begin : g_off
    if (i < OffW) begin : g_in
      assign xoff[i] = cfg_i.checker_x_offset[i];
      assign yoff[i] = cfg_i.checker_y_offset[i];
    end else begin : g_zero
      assign xoff[i] = 1'b0;
      assign yoff[i] = 1'b0;
    end
  end

  assign xsum   = {1'b0, pix_i.out_column} + {1'b0, xoff};
  assign ysum   = {1'b0, pix_i.out_row} + {1'b0, yoff};
  assign xsh    = xsum >> cfg_i.checker_shift;
  assign ysh    = ysum >> cfg_i.checker_shift;
  assign pick_d = xsh[0] ^ ysh[0];

  assign amul    = pix_i.src_alpha * cfg_i.overall_opacity;
  assign abias   = amul + cbac_pkg::AlphaBias;
  assign alpha_d = cfg_i.source_alpha_present ? abias[15:8] : cfg_i.overall_opacity;

  logic [ChanW-1:0] a1_q, r1_q, g1_q, b1_q;
  logic             pick1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && pix_i.valid) begin
      a1_q    <= alpha_d;
      pick1_q <= pick_d;
      r1_q    <= pix_i.src_red;
      g1_q    <= pix_i.src_green;
      b1_q    <= pix_i.src_blue;
    end
  end

  // ---- stage 2: checker colour, signed difference times alpha
  logic [cbac_pkg::ColorW-1:0] chk;
  logic [ChanW-1:0]            cr, cg, cb;
  logic signed [ChanW:0]       dr, dg, db, aext;
  logic signed [2*ChanW+1:0]   pr_d, pg_d, pb_d;

  assign chk  = pick1_q ? cfg_i.color_two : cfg_i.color_one;
  assign cr   = chk[23:16];
  assign cg   = chk[15:8];
  assign cb   = chk[7:0];
  assign dr   = $signed({1'b0, r1_q}) - $signed({1'b0, cr});
  assign dg   = $signed({1'b0, g1_q}) - $signed({1'b0, cg});
  assign db   = $signed({1'b0, b1_q}) - $signed({1'b0, cb});
  assign aext = $signed({1'b0, a1_q});
  assign pr_d = dr * aext;
  assign pg_d = dg * aext;
  assign pb_d = db * aext;

  logic signed [2*ChanW+1:0] pr2_q, pg2_q, pb2_q;
  logic [ChanW-1:0]          sr2_q, sg2_q, sb2_q, cr2_q, cg2_q, cb2_q;
  logic                      azero2_q, afull2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      pr2_q    <= pr_d;
      pg2_q    <= pg_d;
      pb2_q    <= pb_d;
      sr2_q    <= r1_q;
      sg2_q    <= g1_q;
      sb2_q    <= b1_q;
      cr2_q    <= cr;
      cg2_q    <= cg;
      cb2_q    <= cb;
      azero2_q <= (a1_q == cbac_pkg::AlphaClear);
      afull2_q <= (a1_q == cbac_pkg::AlphaOpaque);
    end
  end

  // ---- stage 3: rounding on the 18-bit product sign-extended to 24 bits; clear or opaque alpha bypasses it
  function automatic logic [ChanW-1:0] round_chan(logic signed [2*ChanW+1:0] p,
                                                  logic [ChanW-1:0] c);
    logic [23:0] t;
    logic [15:0] s;
    t = 24'(p);
    s = t[15:0] + t[23:8] + cbac_pkg::RoundHalf;
    return c + s[15:8];
  endfunction

  logic [ChanW-1:0] or_d, og_d, ob_d;

  always_comb begin
    priority if (azero2_q) begin
      or_d = cr2_q;
      og_d = cg2_q;
      ob_d = cb2_q;
    end else if (afull2_q) begin
      or_d = sr2_q;
      og_d = sg2_q;
      ob_d = sb2_q;
    end else begin
      or_d = round_chan(pr2_q, cr2_q);
      og_d = round_chan(pg2_q, cg2_q);
      ob_d = round_chan(pb2_q, cb2_q);
    end
  end

  logic [ChanW-1:0] or3_q, og3_q, ob3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      or3_q <= or_d;
      og3_q <= og_d;
      ob3_q <= ob_d;
    end
  end

  // the user must keep the configuration static while results are outstanding; the block does not enforce it
  assign pix_o.valid       = v3_q;
  assign pix_o.dst_red     = or3_q;
  assign pix_o.dst_green   = og3_q;
  assign pix_o.dst_blue    = ob3_q;
  assign pix_o.alpha_write = cfg_i.four_channel_output;
  assign pix_o.dst_alpha   = cfg_i.four_channel_output ? cbac_pkg::AlphaOpaque
                                                       : cbac_pkg::AlphaClear;

endmodule

@@ design/checkerboard_alpha_composite.sv @@
// Checkerboard alpha compositor, top level.
// Each input transaction passes the stage 1, stage 2 and stage 3 registers before its result is valid.
// Throughput: one pixel per clock while the output is ready; stages hold independently under back-pressure.
// Reset (rst_ni low, async): pipeline emptied, registers return to defaults.
// Depends on cbac_pkg, cbac_intf, cbac_regs and cbac_pipe.
module checkerboard_alpha_composite #(
  parameter int unsigned CoordBits = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbac_pkg::ApbAddrW-1:0] paddr,
  input  logic [cbac_pkg::ApbDataW-1:0] pwdata,
  output logic [cbac_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  cbac_in_if.sink                       pix_i,
  cbac_out_if.source                    pix_o
);

  cbac_pkg::cfg_t cfg;

  cbac_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbac_pipe #(
    .CoordBits (CoordBits)
  ) u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .pix_i  (pix_i),
    .pix_o  (pix_o)
  );

endmodule

@@ design/cbac_sva.sv @@
// Port-level checks for the compositor, attached by bind.
// Depends only on the top level's port signals.
module cbac_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] dst_red,
  input logic [7:0] dst_green,
  input logic [7:0] dst_blue,
  input logic [7:0] dst_alpha,
  input logic       alpha_write
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid)
    else $error("result valid straight after reset");

  // with the output stage empty nothing downstream can hold the input back
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_alpha_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (alpha_write ? (dst_alpha == 8'hff) : (dst_alpha == 8'h00)))
    else $error("alpha byte disagrees with alpha write flag");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(dst_red) && $stable(dst_green) && $stable(dst_blue))
    else $error("result changed while stalled");

endmodule

bind checkerboard_alpha_composite cbac_sva u_cbac_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (pix_i.ready),
  .out_valid   (pix_o.valid),
  .out_ready   (pix_o.ready),
  .dst_red     (pix_o.dst_red),
  .dst_green   (pix_o.dst_green),
  .dst_blue    (pix_o.dst_blue),
  .dst_alpha   (pix_o.dst_alpha),
  .alpha_write (pix_o.alpha_write)
);
